>>> rtl/pba_pkg.sv
// Shared types, codes and helpers for the page bitmap allocator.
// Depends on nothing; every other file of the block refers to it by scoped names.
package pba_pkg;

    // Default sizing of the allocator.
    localparam int NUM_PAGES_DEF  = 4096;
    localparam int PAGE_BYTES_DEF = 4096;

    // Fixed widths of the word fields.
    localparam int BYTES_W = 25;
    localparam int PIDX_W  = 12;

    // The rounded-up byte count needs one bit more than the request.
    localparam int DIV_W = BYTES_W + 1;

    // Bitmap byte constants.
    localparam logic [7:0] BYTE_FULL = 8'hFF;
    localparam logic [2:0] BIT_SEL   = 3'h7;

    // Operation codes.
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Status codes.
    localparam logic ST_DONE     = 1'b0;
    localparam logic ST_NO_SPACE = 1'b1;

    // Request word.
    typedef struct packed {
        logic               opcode;
        logic [BYTES_W-1:0] alloc_bytes;
        logic [PIDX_W-1:0]  free_page;
    } pba_in_t;

    // Result word.
    typedef struct packed {
        logic [PIDX_W-1:0] page_index;
        logic              status;
    } pba_out_t;

    // Position of the lowest clear bit of a bitmap byte (zero if none is clear).
    function automatic logic [2:0] first_zero(input logic [7:0] map_byte);
        logic [2:0] pos;
        logic       hit;
        pos = 3'd0;
        hit = 1'b0;
        for (int i = 0; i < 8; i++) begin
            if (!hit && !map_byte[i]) begin
                pos = 3'(i);
                hit = 1'b1;
            end
        end
        return pos;
    endfunction

endpackage

>>> rtl/page_bitmap_allocator.sv
// Page bitmap allocator: bitmap memory, scan and run-marking sequencer, output register.
// Depends on pba_pkg for the word types, codes and the clear-bit search.
//
// Usage:
//   Requests arrive on s_valid/s_ready/s_data, one word each: allocate
//   (alloc_bytes) or free one page (free_page). Each request returns exactly
//   one result word on m_valid/m_ready/m_data, in request order.
//   The used-page bitmap lives in a byte-wide memory, one bit per page.
//   Steps from acceptance to m_valid, with the output free:
//     free                     : read the byte and clear the page's bit (a page
//                                beyond the map answers without a memory access).
//     allocate of one page     : read bitmap bytes one by one from the lowest
//                                byte that may hold a free page, until one has a clear bit.
//     allocate of a longer run : reciprocal multiplication for the run length,
//                                a fit check, then read and write-back of each
//                                byte it covers (no fit: answer after the check).
//   The block takes one request at a time; s_ready is high only when idle,
//   so the next request is taken only once the previous result has gone to
//   the output register. The single memory read port paces scans and runs.
//   After reset, the bitmap is cleared one byte per cycle, all (NUM_PAGES + 7) / 8
//   bytes of it (512 by default); s_ready stays low meanwhile.
//   A result waits in the output register while m_ready is low; the next
//   request is still accepted and runs until its own result is ready.
module page_bitmap_allocator #(
    parameter int NUM_PAGES  = pba_pkg::NUM_PAGES_DEF,
    parameter int PAGE_BYTES = pba_pkg::PAGE_BYTES_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  pba_pkg::pba_in_t s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output pba_pkg::pba_out_t m_data
);

    // Sizing derived from the parameters.
    localparam int MAP_BYTES = (NUM_PAGES + 7) / 8;
    localparam int ADDR_W    = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
    localparam int CNT_W     = $clog2(MAP_BYTES + 1);
    localparam int PAGE_W    = $clog2(NUM_PAGES + 1);
    localparam int RW        = $clog2(PAGE_BYTES);
    localparam int DIV_W     = pba_pkg::DIV_W;
    localparam int PIDX_W    = pba_pkg::PIDX_W;

    // Reciprocal of the page size, exact for every rounded-up byte count.
    localparam int              RECIP_SH = DIV_W + RW;
    localparam int              RECIP_W  = DIV_W + 1;
    localparam int              PROD_W   = DIV_W + RECIP_W;
    localparam longint unsigned RECIP    =
        ((64'd1 << RECIP_SH) + 64'(PAGE_BYTES) - 64'd1) / 64'(PAGE_BYTES);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FREE,
        S_SCAN,
        S_DIV,
        S_FIT,
        S_RUN,
        S_DONE
    } state_t;

    // Bitmap memory, one read port and one write port.
    logic [7:0]        map_mem [MAP_BYTES];
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data_reg;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;

    // Control state.
    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       clr_reg, clr_next;
    logic [CNT_W-1:0]       hint_reg, hint_next;
    logic [PAGE_W-1:0]      high_mark_reg, high_mark_next;
    logic [CNT_W-1:0]       scan_reg, scan_next;
    logic                   pend_reg, pend_next;
    logic                   m_valid_reg, m_valid_next;

    // Working payload.
    logic [CNT_W-1:0]       byte_reg, byte_next;
    logic [2:0]             bit_reg, bit_next;
    logic [CNT_W-1:0]       first_byte_reg, first_byte_next;
    logic [CNT_W-1:0]       last_byte_reg, last_byte_next;
    logic [2:0]             start_lo_reg, start_lo_next;
    logic [2:0]             end_hi_reg, end_hi_next;
    logic [DIV_W-1:0]       quot_reg, quot_next;
    pba_pkg::pba_out_t      res_reg, res_next;
    pba_pkg::pba_out_t      m_data_reg, m_data_next;

    // Helper values.
    logic [CNT_W-1:0]       free_byte;
    logic [2:0]             zero_bit;
    logic [CNT_W+2:0]       scan_page;
    logic                   scan_hit;
    logic [PROD_W-1:0]      quot_prod;
    logic [PAGE_W-1:0]      run_end;
    logic [PAGE_W-1:0]      run_last;
    logic [31:0]            avail;
    logic [2:0]             mask_lo;
    logic [2:0]             mask_hi;
    logic [7:0]             run_mask;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Memory write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            map_mem[wr_addr] <= wr_data;
        end
    end

    // Memory read port with registered data.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= map_mem[rd_addr];
        end
    end

    // Values used by several states.
    always_comb begin
        free_byte = CNT_W'(s_data.free_page >> 3);
        zero_bit  = pba_pkg::first_zero(rd_data_reg);
        scan_page = {byte_reg, zero_bit};
        scan_hit  = pend_reg && (rd_data_reg != pba_pkg::BYTE_FULL);
        quot_prod = PROD_W'(quot_reg) * PROD_W'(RECIP);
        avail     = 32'(NUM_PAGES) - 32'(high_mark_reg);
        run_end   = high_mark_reg + PAGE_W'(quot_reg);
        run_last  = run_end - PAGE_W'(1);
        mask_lo   = (byte_reg == first_byte_reg) ? start_lo_reg : 3'd0;
        mask_hi   = (byte_reg == last_byte_reg) ? end_hi_reg : pba_pkg::BIT_SEL;
        run_mask  = (pba_pkg::BYTE_FULL << mask_lo)
                  & (pba_pkg::BYTE_FULL >> (pba_pkg::BIT_SEL - mask_hi));
    end

    // Sequencer: next state, memory port control and result forming.
    always_comb begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        hint_next       = hint_reg;
        high_mark_next  = high_mark_reg;
        scan_next       = scan_reg;
        pend_next       = pend_reg;
        byte_next       = byte_reg;
        bit_next        = bit_reg;
        first_byte_next = first_byte_reg;
        last_byte_next  = last_byte_reg;
        start_lo_next   = start_lo_reg;
        end_hi_next     = end_hi_reg;
        quot_next       = quot_reg;
        res_next        = res_reg;
        m_data_next     = m_data_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        rd_en           = 1'b0;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = '0;

        unique case (state_reg)
            // Clear the bitmap one byte per cycle after reset.
            S_CLEAR: begin
                wr_en    = 1'b1;
                wr_addr  = ADDR_W'(clr_reg);
                clr_next = clr_reg + CNT_W'(1);
                if (clr_reg == CNT_W'(MAP_BYTES - 1)) begin
                    state_next = S_IDLE;
                end
            end

            // Take a request and start the matching operation.
            S_IDLE: begin
                if (s_valid) begin
                    res_next.page_index = '0;
                    res_next.status     = pba_pkg::ST_DONE;
                    if (s_data.opcode == pba_pkg::OP_FREE) begin
                        if (32'(s_data.free_page) < 32'(NUM_PAGES)) begin
                            rd_en      = 1'b1;
                            rd_addr    = ADDR_W'(free_byte);
                            byte_next  = free_byte;
                            bit_next   = s_data.free_page[2:0];
                            if (free_byte < hint_reg) begin
                                hint_next = free_byte;
                            end
                            state_next = S_FREE;
                        end else begin
                            state_next = S_DONE;
                        end
                    end else if (32'(s_data.alloc_bytes) <= 32'(PAGE_BYTES)) begin
                        scan_next  = hint_reg;
                        pend_next  = 1'b0;
                        state_next = S_SCAN;
                    end else begin
                        quot_next  = DIV_W'(s_data.alloc_bytes) + DIV_W'(PAGE_BYTES - 1);
                        state_next = S_DIV;
                    end
                end
            end

            // Clear the freed page's bit.
            S_FREE: begin
                wr_en      = 1'b1;
                wr_addr    = ADDR_W'(byte_reg);
                wr_data    = rd_data_reg & ~(8'd1 << bit_reg);
                state_next = S_DONE;
            end

            // Read bytes from the hint on; stop at the first one with a clear bit.
            S_SCAN: begin
                if (scan_hit) begin
                    if (32'(scan_page) >= 32'(NUM_PAGES)) begin
                        res_next.status = pba_pkg::ST_NO_SPACE;
                    end else begin
                        wr_en     = 1'b1;
                        wr_addr   = ADDR_W'(byte_reg);
                        wr_data   = rd_data_reg | (8'd1 << zero_bit);
                        hint_next = byte_reg;
                        if (32'(scan_page) >= 32'(high_mark_reg)) begin
                            high_mark_next = PAGE_W'(32'(scan_page) + 32'd1);
                        end
                        res_next.page_index = PIDX_W'(scan_page);
                    end
                    state_next = S_DONE;
                end else if (scan_reg < CNT_W'(MAP_BYTES)) begin
                    rd_en     = 1'b1;
                    rd_addr   = ADDR_W'(scan_reg);
                    byte_next = scan_reg;
                    pend_next = 1'b1;
                    scan_next = scan_reg + CNT_W'(1);
                end else begin
                    res_next.status = pba_pkg::ST_NO_SPACE;
                    state_next      = S_DONE;
                end
            end

            // Run length as the rounded-up byte count times the page-size reciprocal.
            S_DIV: begin
                quot_next  = DIV_W'(quot_prod >> RECIP_SH);
                state_next = S_FIT;
            end

            // Check that the run fits above the mark and set up the byte range.
            S_FIT: begin
                if (32'(quot_reg) > avail) begin
                    res_next.status = pba_pkg::ST_NO_SPACE;
                    state_next      = S_DONE;
                end else begin
                    first_byte_next     = CNT_W'(high_mark_reg >> 3);
                    scan_next           = CNT_W'(high_mark_reg >> 3);
                    last_byte_next      = CNT_W'(run_last >> 3);
                    start_lo_next       = high_mark_reg[2:0];
                    end_hi_next         = run_last[2:0];
                    res_next.page_index = PIDX_W'(high_mark_reg);
                    high_mark_next      = run_end;
                    pend_next           = 1'b0;
                    state_next          = S_RUN;
                end
            end

            // Read the next byte of the run while writing back the previous one.
            S_RUN: begin
                if (pend_reg) begin
                    wr_en   = 1'b1;
                    wr_addr = ADDR_W'(byte_reg);
                    wr_data = rd_data_reg | run_mask;
                end
                if (scan_reg <= last_byte_reg) begin
                    rd_en     = 1'b1;
                    rd_addr   = ADDR_W'(scan_reg);
                    byte_next = scan_reg;
                    pend_next = 1'b1;
                    scan_next = scan_reg + CNT_W'(1);
                end else begin
                    pend_next  = 1'b0;
                    state_next = S_DONE;
                end
            end

            // Hand the result to the output register once it is free.
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            hint_reg      <= '0;
            high_mark_reg <= '0;
            scan_reg      <= '0;
            pend_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            hint_reg      <= hint_next;
            high_mark_reg <= high_mark_next;
            scan_reg      <= scan_next;
            pend_reg      <= pend_next;
            m_valid_reg   <= m_valid_next;
        end
        byte_reg       <= byte_next;
        bit_reg        <= bit_next;
        first_byte_reg <= first_byte_next;
        last_byte_reg  <= last_byte_next;
        start_lo_reg   <= start_lo_next;
        end_hi_reg     <= end_hi_next;
        quot_reg       <= quot_next;
        res_reg        <= res_next;
        m_data_reg     <= m_data_next;
    end

    // The mark never passes the end of the map.
    a_mark_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(high_mark_reg) <= 32'(NUM_PAGES))
        else $error("high mark beyond the page count");

    // The scan hint always names a byte of the map.
    a_hint_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        hint_reg < CNT_W'(MAP_BYTES))
        else $error("scan hint outside the bitmap");

    // Run marking never reads and writes the same byte in one cycle.
    a_run_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RUN && rd_en && wr_en) |-> (rd_addr != wr_addr))
        else $error("run marking read and write collide");

    // No bitmap write while waiting for a request.
    a_idle_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !wr_en)
        else $error("bitmap written while idle");

    // An accepted request produces no result in the following cycle.
    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !m_valid) |=> !m_valid)
        else $error("result appeared too early");

endmodule

>>> dv/page_bitmap_allocator_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the page bitmap allocator: keeps its own page bitmap and high-water mark,
// works out the result word owed for every accepted request and compares it on return.
// Depends on pba_pkg for the word types and the operation and status codes.
module page_bitmap_allocator_checker #(
    parameter int NUM_PAGES  = pba_pkg::NUM_PAGES_DEF,
    parameter int PAGE_BYTES = pba_pkg::PAGE_BYTES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  pba_pkg::pba_in_t  s_data,
    input  logic              m_valid,
    input  logic              m_ready,
    input  pba_pkg::pba_out_t m_data,
    output int unsigned       errors,
    output int unsigned       pending,
    output int unsigned       high_water,
    output int unsigned       free_pages,
    output int unsigned       refusals
);

    localparam int PIDX_W = pba_pkg::PIDX_W;

    // Predicted allocator state.
    logic [NUM_PAGES-1:0] used_pages;
    int unsigned          used_count;
    int unsigned          mark;

    // Result words the block still owes, oldest first.
    pba_pkg::pba_out_t    owed_results[$];

    // Marks one page as used and keeps the used-page count in step.
    function automatic void take_page(input int unsigned page);
        if (!used_pages[page]) begin
            used_count++;
        end
        used_pages[page] = 1'b1;
    endfunction

    // Applies one request to the predicted state and returns the word it must produce.
    function automatic pba_pkg::pba_out_t serve_request(input pba_pkg::pba_in_t req);
        pba_pkg::pba_out_t grant;
        int unsigned       page;
        int unsigned       run_len;
        grant.page_index = '0;
        grant.status     = pba_pkg::ST_DONE;
        if (req.opcode == pba_pkg::OP_FREE) begin
            if (req.free_page < NUM_PAGES && used_pages[req.free_page]) begin
                used_pages[req.free_page] = 1'b0;
                used_count--;
            end
        end else if (req.alloc_bytes <= PAGE_BYTES) begin
            // Lowest clear bit of the whole map, or NUM_PAGES when the map is full.
            page = NUM_PAGES;
            for (int p = NUM_PAGES - 1; p >= 0; p--) begin
                if (!used_pages[p]) begin
                    page = p;
                end
            end
            if (page == NUM_PAGES) begin
                grant.status = pba_pkg::ST_NO_SPACE;
            end else begin
                take_page(page);
                if (page >= mark) begin
                    mark = page + 1;
                end
                grant.page_index = PIDX_W'(page);
            end
        end else begin
            // A longer request claims a rounded-up run at the mark if it fits, pages unchecked.
            run_len = req.alloc_bytes;
            run_len = (run_len + PAGE_BYTES - 1) / PAGE_BYTES;
            if (mark > NUM_PAGES || run_len > NUM_PAGES - mark) begin
                grant.status = pba_pkg::ST_NO_SPACE;
            end else begin
                for (int unsigned k = 0; k < run_len; k++) begin
                    take_page(mark + k);
                end
                grant.page_index = PIDX_W'(mark);
                mark += run_len;
            end
        end
        return grant;
    endfunction

    // Both channels are sampled on the rising edge, which also registers the exported counts.
    always @(posedge aclk) begin
        pba_pkg::pba_out_t want;
        int unsigned       bad;
        bad = 0;
        if (!aresetn) begin
            used_pages = '0;
            used_count = 0;
            mark       = 0;
            owed_results.delete();
            errors   <= 0;
            refusals <= 0;
        end else begin
            if (s_valid && s_ready) begin
                owed_results.push_back(serve_request(s_data));
            end
            if (m_valid && m_ready) begin
                if (owed_results.size() == 0) begin
                    $display("%0t: result word with none owed: page_index=%0d status=%0d",
                             $time, m_data.page_index, m_data.status);
                    bad++;
                end else begin
                    want = owed_results.pop_front();
                    if (m_data.page_index !== want.page_index) begin
                        $display("%0t: page_index expected %0d, got %0d",
                                 $time, want.page_index, m_data.page_index);
                        bad++;
                    end
                    if (m_data.status !== want.status) begin
                        $display("%0t: status expected %0d, got %0d",
                                 $time, want.status, m_data.status);
                        bad++;
                    end
                    if (want.status == pba_pkg::ST_NO_SPACE) begin
                        refusals <= refusals + 1;
                    end
                end
            end
            errors <= errors + bad;
        end
        pending    <= owed_results.size();
        high_water <= mark;
        free_pages <= NUM_PAGES - used_count;
    end

endmodule

>>> dv/page_bitmap_allocator_test.sv
`timescale 1ns / 1ps
// Top of the page bitmap allocator testbench: clock, reset, request and result traffic
// and the verdict. Depends on pba_pkg, the allocator RTL and page_bitmap_allocator_checker.
module page_bitmap_allocator_test;

    localparam int NPAGES    = pba_pkg::NUM_PAGES_DEF;
    localparam int PAGE_SZ   = pba_pkg::PAGE_BYTES_DEF;
    localparam int BYTES_W   = pba_pkg::BYTES_W;
    localparam int PIDX_W    = pba_pkg::PIDX_W;
    localparam int MAX_BYTES = (1 << BYTES_W) - 1;
    // The receiver stops taking words for this long once, after this many results.
    localparam int LONG_HOLD = 600;
    localparam int HOLD_AT   = 60;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    pba_pkg::pba_in_t  s_data;
    logic              m_valid;
    logic              m_ready;
    pba_pkg::pba_out_t m_data;

    int unsigned errors;
    int unsigned pending;
    int unsigned high_water;
    int unsigned free_pages;
    int unsigned refusals;

    int unsigned n_alloc;
    int unsigned n_free;
    int unsigned n_runs;
    bit          tx_quiet;
    bit          rx_quiet;
    bit          wide_sizes;

    page_bitmap_allocator dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    page_bitmap_allocator_checker watch (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .errors     (errors),
        .pending    (pending),
        .high_water (high_water),
        .free_pages (free_pages),
        .refusals   (refusals)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #200_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    function automatic pba_pkg::pba_in_t make_request(input logic op,
                                                      input int unsigned bytes,
                                                      input int unsigned page);
        pba_pkg::pba_in_t req;
        req.opcode      = op;
        req.alloc_bytes = BYTES_W'(bytes);
        req.free_page   = PIDX_W'(page);
        return req;
    endfunction

    // Mostly allocates of one page and frees below the mark, with runs mixed in.
    // The unused field of each word carries random noise.
    function automatic pba_pkg::pba_in_t random_request();
        pba_pkg::pba_in_t req;
        int unsigned      pick;
        req.opcode      = pba_pkg::OP_ALLOC;
        req.alloc_bytes = BYTES_W'($urandom());
        req.free_page   = PIDX_W'($urandom());
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            req.alloc_bytes = BYTES_W'($urandom_range(0, PAGE_SZ));
        end else if (pick < 55) begin
            req.alloc_bytes = BYTES_W'($urandom_range(PAGE_SZ + 1, 8 * PAGE_SZ));
        end else if (pick < 60) begin
            // Full-width sizes would use up the map early, so they wait for the last phase.
            if (!wide_sizes) begin
                req.alloc_bytes = BYTES_W'($urandom_range(8 * PAGE_SZ + 1, 32 * PAGE_SZ));
            end
        end else begin
            req.opcode = pba_pkg::OP_FREE;
            if (pick < 90 && high_water > 0) begin
                req.free_page = PIDX_W'($urandom_range(0, high_water - 1));
            end
        end
        return req;
    endfunction

    // Offers one request word after a random gap and waits until it is taken.
    task automatic offer_request(input pba_pkg::pba_in_t req);
        int unsigned gap;
        if ($urandom_range(0, 39) == 0) begin
            tx_quiet = !tx_quiet;
        end
        gap = tx_quiet ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_data  <= req;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (req.opcode == pba_pkg::OP_FREE) begin
            n_free++;
        end else begin
            n_alloc++;
            if (req.alloc_bytes > PAGE_SZ) begin
                n_runs++;
            end
        end
    endtask

    // Holds the request side idle until every owed result word has come back.
    task automatic wait_for_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    // Result side: random stalls, quiet stretches, and one long hold-off.
    initial begin
        int unsigned gap;
        int unsigned taken;
        taken = 0;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if ($urandom_range(0, 39) == 0) begin
                rx_quiet = !rx_quiet;
            end
            gap = rx_quiet ? 0 : $urandom_range(0, 19);
            if (taken == HOLD_AT) begin
                gap = LONG_HOLD;
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!(m_valid && m_ready)) @(posedge aclk);
            taken++;
        end
    end

    // Request side and verdict.
    initial begin
        int unsigned room;
        int unsigned fills;
        n_alloc    = 0;
        n_free     = 0;
        n_runs     = 0;
        tx_quiet   = 1'b0;
        rx_quiet   = 1'b0;
        wide_sizes = 1'b0;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Zero-byte allocate, the smallest size and exactly one page.
        offer_request(make_request(pba_pkg::OP_ALLOC, 0, 0));
        offer_request(make_request(pba_pkg::OP_ALLOC, 1, 0));
        offer_request(make_request(pba_pkg::OP_ALLOC, PAGE_SZ, 0));
        // Shortest run, rounded up from one byte over a page.
        offer_request(make_request(pba_pkg::OP_ALLOC, PAGE_SZ + 1, 0));
        // The largest field value and a run the size of the whole map run past the end.
        offer_request(make_request(pba_pkg::OP_ALLOC, MAX_BYTES, NPAGES - 1));
        offer_request(make_request(pba_pkg::OP_ALLOC, 1 << 24, 0));
        // Free, free of a page already free, then reuse of the hole.
        offer_request(make_request(pba_pkg::OP_FREE, MAX_BYTES, 1));
        offer_request(make_request(pba_pkg::OP_FREE, 0, 1));
        offer_request(make_request(pba_pkg::OP_ALLOC, PAGE_SZ - 1, 0));
        // Top page, never handed out, then the lowest page freed and taken again.
        offer_request(make_request(pba_pkg::OP_FREE, 0, NPAGES - 1));
        offer_request(make_request(pba_pkg::OP_FREE, 0, 0));
        offer_request(make_request(pba_pkg::OP_ALLOC, 0, NPAGES - 1));
        // Runs of exactly two pages and just over two.
        offer_request(make_request(pba_pkg::OP_ALLOC, 2 * PAGE_SZ, 0));
        offer_request(make_request(pba_pkg::OP_ALLOC, 2 * PAGE_SZ + 1, 0));
        // Holes inside a run, filled again by single-page allocates.
        offer_request(make_request(pba_pkg::OP_FREE, 0, 3));
        offer_request(make_request(pba_pkg::OP_FREE, 0, 4));
        offer_request(make_request(pba_pkg::OP_ALLOC, 1, 0));
        offer_request(make_request(pba_pkg::OP_ALLOC, 1, 0));

        // Random traffic; the long hold-off on the result side falls in here.
        repeat (800) offer_request(random_request());
        wait_for_results();
        repeat (600) offer_request(random_request());

        // Run that does not fit by one page, then one that fills the map to the end.
        wait_for_results();
        room = NPAGES - high_water;
        if (room >= 2) begin
            offer_request(make_request(pba_pkg::OP_ALLOC, (room + 1) * PAGE_SZ, $urandom()));
            offer_request(make_request(pba_pkg::OP_ALLOC,
                                       room * PAGE_SZ - $urandom_range(0, PAGE_SZ - 1),
                                       $urandom()));
        end

        // Take every remaining hole, then ask for more with the map full.
        wait_for_results();
        fills = free_pages + 2;
        repeat (fills) begin
            offer_request(make_request(pba_pkg::OP_ALLOC, $urandom_range(0, PAGE_SZ),
                                       $urandom()));
        end

        // Churn on a nearly full map with sizes over the whole field.
        wide_sizes = 1'b1;
        repeat (60) offer_request(random_request());

        wait_for_results();
        repeat (600) @(posedge aclk);
        $display("Sent %0d allocates (%0d of them multi-page runs) and %0d frees.",
                 n_alloc, n_runs, n_free);
        $display("%0d allocates were refused for lack of space.", refusals);
        if (errors == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/pba_pkg.sv
rtl/page_bitmap_allocator.sv
dv/page_bitmap_allocator_checker.sv
dv/page_bitmap_allocator_test.sv
